[design/boolean_query_score_accumulator_defines.svh]
// Assertion macros for the boolean query score accumulator.
// No dependencies; taken in by `include in the modules that assert.
`ifndef BOOLEAN_QUERY_SCORE_ACCUMULATOR_DEFINES_SVH
`define BOOLEAN_QUERY_SCORE_ACCUMULATOR_DEFINES_SVH

// property checked on every rising edge outside reset
`define BQSA_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("bqsa assertion failed");

// condition that must never hold outside reset
`define BQSA_NEVER(lbl, ck, rn, cond) \
	`BQSA_ASSERT(lbl, ck, rn, !(cond))

`endif

[design/bqsa_pkg.sv]
// Package of the boolean query score accumulator: commands, queue item,
// back-end state type and the saturating add. No dependencies.
package bqsa_pkg;

	localparam logic [2:0] CMD_OR_POST  = 3'd0;
	localparam logic [2:0] CMD_AND_POST = 3'd1;
	localparam logic [2:0] CMD_MERGE    = 3'd2;
	localparam logic [2:0] CMD_READ     = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	localparam logic [9:0] MAX_DOC_RST = 10'd1023;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [2:0] {
		OP_OR,
		OP_AND,
		OP_MERGE,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_POST,
		ST_READ,
		ST_MERGE,
		ST_DRAIN,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [9:0]  doc;
		logic [15:0] freq;
		logic        in_range;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

[design/boolean_query_score_accumulator.sv]
// Read: the score is fetched into a read register when the item is popped, then moved
// into the result register; OR/AND posting is a memory read, then a write-back. Merge and
// clear sweep one entry a cycle; merge ends in a drain state for its last write-back.
// Unused commands and out-of-range postings are dropped at the front, taking no back time.
// Reset: asynchronous, active low; then a clearing pass over both tables,
// with in_ready low. max_doc_id resets to 1023.
module boolean_query_score_accumulator import bqsa_pkg::*; #(
	parameter int DOCS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [9:0]  doc_id,
	input  logic [15:0] freq,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  doc_id_out,
	output logic [31:0] score
);

	logic [9:0] max_doc_id_q;
	logic       push;
	q_item_t    push_item;
	q_item_t    q_head;
	q_stat_t    q_stat;
	logic       q_pop;
	logic       init_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_doc_id_q <= MAX_DOC_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_doc_id_q <= cfg_data;
		end
	end

	bqsa_front #(.DOCS(DOCS)) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.doc_id    (doc_id),
		.freq      (freq),
		.q_stat    (q_stat),
		.init_busy (init_busy),
		.push      (push),
		.push_item (push_item)
	);

	bqsa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	bqsa_back #(.DOCS(DOCS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_doc_id (max_doc_id_q),
		.q_head     (q_head),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.doc_id_out (doc_id_out),
		.score      (score)
	);

endmodule

[design/bqsa_fifo.sv]
// Short item queue between front and back end.
// Depends on bqsa_pkg (q_item_t, q_stat_t, QDEPTH).
module bqsa_fifo import bqsa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output q_item_t head,
	output q_stat_t stat
);

	q_item_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (QAW + 1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

[design/bqsa_front.sv]
// Front end: takes input items, decodes the command, drops items that
// change nothing and queues the rest. Depends on bqsa_pkg.
module bqsa_front import bqsa_pkg::*; #(
	parameter int DOCS = 1024
) (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [9:0]  doc_id,
	input  logic [15:0] freq,
	input  q_stat_t     q_stat,
	input  logic        init_busy,
	output logic        push,
	output q_item_t     push_item
);

	logic keep;
	logic in_range;

	assign in_range = (32'(doc_id) < 32'(DOCS));

	always_comb begin
		keep               = 1'b0;
		push_item.op       = OP_OR;
		push_item.doc      = doc_id;
		push_item.freq     = freq;
		push_item.in_range = in_range;
		case (cmd)
			CMD_OR_POST: begin
				push_item.op = OP_OR;
				keep         = in_range;
			end
			CMD_AND_POST: begin
				push_item.op = OP_AND;
				keep         = in_range;
			end
			CMD_MERGE: begin
				push_item.op = OP_MERGE;
				keep         = 1'b1;
			end
			CMD_READ: begin
				push_item.op = OP_READ;
				keep         = 1'b1;
			end
			CMD_CLEAR: begin
				push_item.op = OP_CLEAR;
				keep         = 1'b1;
			end
			default: begin
				push_item.op = OP_OR;
				keep         = 1'b0;
			end
		endcase
	end

	assign in_ready = !q_stat.full && !init_busy;
	assign push     = in_valid && in_ready && keep;

endmodule

[design/bqsa_back.sv]
// Back end: score and term memories, command sequencer, sweeps and the
// result register. Depends on bqsa_pkg and the assertion macro header.
`include "boolean_query_score_accumulator_defines.svh"

module bqsa_back import bqsa_pkg::*; #(
	parameter int DOCS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [9:0]  max_doc_id,
	input  q_item_t     q_head,
	input  q_stat_t     q_stat,
	output logic        q_pop,
	output logic        init_busy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  doc_id_out,
	output logic [31:0] score
);

	localparam int AW = (DOCS > 1) ? $clog2(DOCS) : 1;

	logic [31:0] score_mem [DOCS];
	logic [31:0] term_mem  [DOCS];
	logic [31:0] score_rd_q;
	logic [31:0] term_rd_q;

	state_t      state_q;
	state_t      state_d;
	logic [AW-1:0] cnt_q;
	logic        cnt_last;
	logic        cnt_run;

	op_t         op_s1;
	logic [AW-1:0] addr_s1;
	logic [9:0]  doc_s1;
	logic [15:0] freq_s1;
	logic        rng_s1;

	logic        mpend_s1;
	logic [AW-1:0] maddr_s1;
	logic        in_win;

	logic [31:0] doc_ext;
	logic [AW-1:0] q_addr;
	logic [AW-1:0] raddr;
	logic        out_free;
	logic        load_out;

	logic        score_we;
	logic [AW-1:0] score_wa;
	logic [31:0] score_wd;
	logic        term_we;
	logic [AW-1:0] term_wa;
	logic [31:0] term_wd;

	logic        out_valid_q;
	logic [9:0]  doc_out_q;
	logic [31:0] score_q;

	assign doc_ext  = 32'(q_head.doc);
	assign q_addr   = doc_ext[AW-1:0];
	assign cnt_last = (cnt_q == AW'(DOCS - 1));
	assign out_free = !out_valid_q || out_ready;
	assign in_win   = (maddr_s1 != '0) && (32'(maddr_s1) <= 32'(max_doc_id));
	assign raddr    = (state_q == ST_MERGE) ? cnt_q : q_addr;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_stat.empty) begin
					case (q_head.op)
						OP_OR, OP_AND: state_d = ST_POST;
						OP_MERGE:      state_d = ST_MERGE;
						OP_READ:       state_d = out_free ? ST_READ : ST_IDLE;
						OP_CLEAR:      state_d = ST_CLEAR;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_POST:  state_d = ST_IDLE;
			ST_READ:  state_d = ST_IDLE;
			ST_MERGE: begin
				if (cnt_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_IDLE;
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			default:  state_d = ST_INIT;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		cnt_run   = 1'b0;
		load_out  = 1'b0;
		init_busy = 1'b0;
		score_we  = 1'b0;
		score_wa  = cnt_q;
		score_wd  = '0;
		term_we   = 1'b0;
		term_wa   = cnt_q;
		term_wd   = '0;
		case (state_q)
			ST_INIT: begin
				init_busy = 1'b1;
				cnt_run   = 1'b1;
				score_we  = 1'b1;
				term_we   = 1'b1;
			end
			ST_IDLE: begin
				q_pop = !q_stat.empty && ((q_head.op != OP_READ) || out_free);
			end
			ST_POST: begin
				if (op_s1 == OP_OR) begin
					score_we = 1'b1;
					score_wa = addr_s1;
					score_wd = sat_add(score_rd_q, 32'(freq_s1));
				end else begin
					term_we = 1'b1;
					term_wa = addr_s1;
					term_wd = sat_add(term_rd_q, 32'(freq_s1));
				end
			end
			ST_READ: begin
				load_out = 1'b1;
			end
			ST_MERGE: begin
				cnt_run = 1'b1;
			end
			ST_CLEAR: begin
				cnt_run  = 1'b1;
				score_we = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
		// merge write-back comes in the cycle after the sweep read
		if (mpend_s1) begin
			term_we  = 1'b1;
			term_wa  = maddr_s1;
			term_wd  = '0;
			score_we = in_win;
			score_wa = maddr_s1;
			score_wd = (term_rd_q != '0) ? sat_add(score_rd_q, term_rd_q) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (score_we) score_mem[score_wa] <= score_wd;
	end

	always_ff @(posedge clk) begin
		if (term_we) term_mem[term_wa] <= term_wd;
	end

	always_ff @(posedge clk) begin
		score_rd_q <= score_mem[raddr];
		term_rd_q  <= term_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1   <= q_head.op;
			addr_s1 <= q_addr;
			doc_s1  <= q_head.doc;
			freq_s1 <= q_head.freq;
			rng_s1  <= q_head.in_range;
		end
		maddr_s1 <= cnt_q;
		if (load_out) begin
			doc_out_q <= doc_s1;
			score_q   <= rng_s1 ? score_rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			mpend_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mpend_s1 <= (state_q == ST_MERGE);
			if (cnt_run) cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign doc_id_out = doc_out_q;
	assign score      = score_q;

	`BQSA_NEVER(a_out_no_overwrite, clk, arst_n, (state_q == ST_READ) && out_valid_q && !out_ready)
	`BQSA_ASSERT(a_post_after_pop, clk, arst_n, (state_q == ST_POST) |-> $past(q_pop))
	`BQSA_ASSERT(a_idle_cnt_zero, clk, arst_n, (state_q == ST_IDLE) |-> (cnt_q == '0))

endmodule
